>>> rtl/core/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

  typedef logic [7:0] char_t;

  localparam char_t ASCII_ZERO  = 8'd48;
  localparam char_t ASCII_MINUS = 8'd45;
  localparam logic [3:0] BCD_FIVE  = 4'd5;
  localparam logic [3:0] BCD_THREE = 4'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_e;

endpackage

>>> rtl/core/sitda_in_if.sv
// Input channel: one signed integer per beat.
interface sitda_in_if #(
  parameter int VALUE_W = 32
);
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> rtl/core/sitda_out_if.sv
// Output channel: one ASCII character per beat with an end-of-text flag.
interface sitda_out_if;
  logic                valid;
  logic                ready;
  sitda_pkg::char_t    character;
  logic                last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter, top level.
// Each beat on in_i carries one signed two's complement integer of INPUT_WIDTH
// bits; the block sends its decimal text on out_o one character per beat, most
// significant first, with a leading '-' for negative values and last set on the
// final character. The magnitude is built into BCD by a shared add-three-and-shift
// unit that takes one input bit per cycle. A number passes through these steps in
// order: one accept step, INPUT_WIDTH conversion steps, one step per leading zero
// digit dropped plus one to leave that step, one for the sign of a negative value
// and one per digit sent; the sign and digit steps wait while the output stalls.
// in_i.ready is high only while the block is idle; the last character may still
// wait in the output register when the next number is taken.
module signed_int_to_decimal_ascii #(
  parameter int INPUT_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sitda_in_if.sink      in_i,
  sitda_out_if.source   out_o
);
  import sitda_pkg::*;

  localparam int NDIG  = ((INPUT_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(INPUT_WIDTH + 1);

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [INPUT_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic                   neg_q, neg_d;
  char_t                  char_q, char_d;
  logic                   last_q, last_d;

  logic [INPUT_WIDTH-1:0] raw;
  logic [BCD_W-1:0]       bcd_step;
  logic [3:0]             top_digit;
  logic                   slot_free;

  sitda_dabble #(.NDIG(NDIG)) u_dabble (
    .bcd_i (bcd_q),
    .bit_i (mag_q[INPUT_WIDTH-1]),
    .bcd_o (bcd_step)
  );

  assign raw       = INPUT_WIDTH'(in_i.value);
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d   = raw[INPUT_WIDTH-1];
          mag_d   = raw[INPUT_WIDTH-1] ? (~raw + INPUT_WIDTH'(1)) : raw;
          bcd_d   = '0;
          cnt_d   = CNT_W'(INPUT_WIDTH);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = bcd_step;
        mag_d = mag_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          cnt_d   = CNT_W'(NDIG);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && cnt_q != CNT_W'(1)) begin
          bcd_d = bcd_q << 4;
          cnt_d = cnt_q - CNT_W'(1);
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          char_d      = ASCII_MINUS;
          last_d      = 1'b0;
          out_valid_d = 1'b1;
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          char_d      = ASCII_ZERO + char_t'(top_digit);
          last_d      = (cnt_q == CNT_W'(1));
          out_valid_d = 1'b1;
          bcd_d       = bcd_q << 4;
          cnt_d       = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

>>> rtl/core/sitda_dabble.sv
// One double-dabble step: add three to every digit of five or more, then shift in one bit.
module sitda_dabble #(
  parameter int NDIG = 10
) (
  input  logic [NDIG*4-1:0] bcd_i,
  input  logic              bit_i,
  output logic [NDIG*4-1:0] bcd_o
);
  import sitda_pkg::*;

  logic [NDIG*4-1:0] adj;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_i[d*4 +: 4] >= BCD_FIVE) begin
        adj[d*4 +: 4] = bcd_i[d*4 +: 4] + BCD_THREE;
      end else begin
        adj[d*4 +: 4] = bcd_i[d*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[NDIG*4-2:0], bit_i};

endmodule
